[hw/rtl/fdb_pkg.sv]
// Shared constants and register codes for the frame difference bounds block.
// No dependencies; imported by frame_difference_bounds_core.
`default_nettype none

package fdb_pkg;

    // Coordinates and result fields are fixed at 16 bits.
    localparam int COORD_W            = 16;
    localparam int PIXEL_BITS_DEFAULT = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_WINDOW_LEFT   = 3'd2,
        REG_WINDOW_TOP    = 3'd3,
        REG_WINDOW_WIDTH  = 3'd4,
        REG_WINDOW_HEIGHT = 3'd5,
        REG_USE_WINDOW    = 3'd6
    } cfg_reg_t;

    // Reset values of the configuration registers.
    localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 16'hFFFF;
    localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 16'hFFFF;
    localparam logic [COORD_W-1:0] WINDOW_LEFT_RST   = 16'd0;
    localparam logic [COORD_W-1:0] WINDOW_TOP_RST    = 16'd0;
    localparam logic [COORD_W-1:0] WINDOW_WIDTH_RST  = 16'd1;
    localparam logic [COORD_W-1:0] WINDOW_HEIGHT_RST = 16'd1;

    // Reset values of the per-frame tracking state.
    localparam logic [COORD_W-1:0] COORD_NONE = 16'hFFFF;
    localparam logic [COORD_W-1:0] COORD_ZERO = 16'd0;
    localparam logic [COORD_W-1:0] COORD_ONE  = 16'd1;

    // Result flag positions in m_tuser.
    localparam int FLAG_CHANGED      = 0;
    localparam int FLAG_COLUMN_FAULT = 1;
    localparam int FLAG_W            = 2;

endpackage

`default_nettype wire

[hw/rtl/frame_difference_bounds_core.sv]
// Frame difference bounds core: top level, one module.
// Depends on fdb_pkg for register codes, widths and reset values.
//
// Usage
// -----
// Pixel pairs arrive on the s_ stream in raster order, one pair per transfer:
// column, row, old and new pixel in s_tdata and the frame's final pair marked
// by s_tlast. The block keeps the smallest rectangle that holds the pixels
// whose old and new values differ, within the searched rows and columns set
// by the configuration registers (window mode or whole screen). Each frame
// yields exactly one result transfer on the m_ stream, issued for the pair
// carrying s_tlast: left, top, width and height in m_tdata, and the changed
// and column fault flags in m_tuser. All other pairs yield nothing.
//
// Throughput is one pair per clock, but for the hold described below: the
// input register feeds a single stage of compares and min/max updates that
// writes the tracking state and the result register. The result of a frame
// is loaded into the result register as its last pair leaves the input
// register, and is offered from there. While a result waits on a stalled
// receiver, pairs that are not last keep flowing; only a further last pair
// is held in the input register until the waiting result has been taken.
//
// Reset clears the tracking state and the handshakes and loads the register
// reset values. The configuration channel is always ready; registers are to
// be written only while no frame is in flight.
`default_nettype none

module frame_difference_bounds_core #(
    parameter int PIXEL_BITS = fdb_pkg::PIXEL_BITS_DEFAULT
) (
    input  wire logic                                       clk,
    input  wire logic                                       rst_n,

    // Input stream. s_tdata, from bit 0: column (16), row (16),
    // old_pixel (PIXEL_BITS), cur_pixel (PIXEL_BITS), zero padding.
    input  wire logic                                       s_tvalid,
    output logic                                            s_tready,
    input  wire logic [((2*fdb_pkg::COORD_W+2*PIXEL_BITS+7)/8)*8-1:0] s_tdata,
    input  wire logic                                       s_tlast,

    // Result stream. m_tdata, from bit 0: box_left (16), box_top (16),
    // box_width (16), box_height (16). m_tuser, from bit 0: changed,
    // column_fault.
    output logic                                            m_tvalid,
    input  wire logic                                       m_tready,
    output logic [4*fdb_pkg::COORD_W-1:0]                   m_tdata,
    output logic [fdb_pkg::FLAG_W-1:0]                      m_tuser,

    // Configuration write channel.
    input  wire logic                                       cfg_valid,
    output logic                                            cfg_ready,
    input  wire logic [fdb_pkg::CFG_INDEX_W-1:0]            cfg_index,
    input  wire logic [fdb_pkg::CFG_DATA_W-1:0]             cfg_data
);

    import fdb_pkg::*;

    localparam int OLD_LO = 2*COORD_W;
    localparam int NEW_LO = 2*COORD_W + PIXEL_BITS;

    // ------------------------------------------------------------------
    // Configuration registers. The channel never stalls.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] screen_width_reg, screen_height_reg;
    logic [COORD_W-1:0] window_left_reg, window_top_reg;
    logic [COORD_W-1:0] window_width_reg, window_height_reg;
    logic               use_window_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
            window_left_reg   <= WINDOW_LEFT_RST;
            window_top_reg    <= WINDOW_TOP_RST;
            window_width_reg  <= WINDOW_WIDTH_RST;
            window_height_reg <= WINDOW_HEIGHT_RST;
            use_window_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                REG_WINDOW_LEFT:   window_left_reg   <= cfg_data;
                REG_WINDOW_TOP:    window_top_reg    <= cfg_data;
                REG_WINDOW_WIDTH:  window_width_reg  <= cfg_data;
                REG_WINDOW_HEIGHT: window_height_reg <= cfg_data;
                REG_USE_WINDOW:    use_window_reg    <= cfg_data[0];
                default:           ; // Writes to unused indexes are dropped.
            endcase
        end
    end

    // Search limits. In window mode the far edges wrap modulo 2^16.
    logic [COORD_W-1:0] s_left, s_right, s_top, s_bottom;

    always_comb
    begin
        if (use_window_reg)
        begin
            s_left   = window_left_reg;
            s_right  = window_left_reg + window_width_reg - COORD_ONE;
            s_top    = window_top_reg;
            s_bottom = window_top_reg + window_height_reg - COORD_ONE;
        end
        else
        begin
            s_left   = COORD_ZERO;
            s_right  = screen_width_reg - COORD_ONE;
            s_top    = COORD_ZERO;
            s_bottom = screen_height_reg - COORD_ONE;
        end
    end

    // ------------------------------------------------------------------
    // Input register.
    // ------------------------------------------------------------------
    logic                  in_valid_reg;
    logic [COORD_W-1:0]    in_column_reg, in_row_reg;
    logic [PIXEL_BITS-1:0] in_old_reg, in_new_reg;
    logic                  in_last_reg;
    logic                  advance;

    // A pair leaves the input register unless it is the last of a frame and
    // the previous result still sits in the result register.
    assign advance  = in_valid_reg && (!in_last_reg || !m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_column_reg <= s_tdata[COORD_W-1:0];
            in_row_reg    <= s_tdata[2*COORD_W-1:COORD_W];
            in_old_reg    <= s_tdata[OLD_LO+PIXEL_BITS-1:OLD_LO];
            in_new_reg    <= s_tdata[NEW_LO+PIXEL_BITS-1:NEW_LO];
            in_last_reg   <= s_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Tracking state and its update for the pair in the input register.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] first_row_reg, final_row_reg;
    logic [COORD_W-1:0] least_column_reg, greatest_column_reg;
    logic               row_found_reg, left_found_reg, right_found_reg;

    logic [COORD_W-1:0] first_row_next, final_row_next;
    logic [COORD_W-1:0] least_column_next, greatest_column_next;
    logic               row_found_next, left_found_next, right_found_next;

    logic hit, left_hit, right_hit;

    // A pair counts when it is on screen, differs and lies in a searched row.
    assign hit = (in_column_reg < screen_width_reg) && (in_row_reg < screen_height_reg)
               && (in_old_reg != in_new_reg)
               && (in_row_reg >= s_top) && (in_row_reg <= s_bottom);
    assign left_hit  = hit && (in_column_reg >= s_left);
    assign right_hit = hit && (in_column_reg <= s_right);

    always_comb
    begin
        first_row_next = (hit && (!row_found_reg || in_row_reg < first_row_reg))
                       ? in_row_reg : first_row_reg;
        final_row_next = (hit && (!row_found_reg || in_row_reg > final_row_reg))
                       ? in_row_reg : final_row_reg;
        row_found_next = row_found_reg || hit;

        least_column_next = (left_hit && (!left_found_reg || in_column_reg < least_column_reg))
                          ? in_column_reg : least_column_reg;
        left_found_next   = left_found_reg || left_hit;

        greatest_column_next =
            (right_hit && (!right_found_reg || in_column_reg > greatest_column_reg))
            ? in_column_reg : greatest_column_reg;
        right_found_next = right_found_reg || right_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_row_reg       <= COORD_NONE;
            final_row_reg       <= COORD_ZERO;
            row_found_reg       <= 1'b0;
            least_column_reg    <= COORD_NONE;
            greatest_column_reg <= COORD_ZERO;
            left_found_reg      <= 1'b0;
            right_found_reg     <= 1'b0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                // The frame is closed: start afresh for the next one.
                first_row_reg       <= COORD_NONE;
                final_row_reg       <= COORD_ZERO;
                row_found_reg       <= 1'b0;
                least_column_reg    <= COORD_NONE;
                greatest_column_reg <= COORD_ZERO;
                left_found_reg      <= 1'b0;
                right_found_reg     <= 1'b0;
            end
            else
            begin
                first_row_reg       <= first_row_next;
                final_row_reg       <= final_row_next;
                row_found_reg       <= row_found_next;
                least_column_reg    <= least_column_next;
                greatest_column_reg <= greatest_column_next;
                left_found_reg      <= left_found_next;
                right_found_reg     <= right_found_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result formation, taken from the state including the last pair.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] res_left, res_top, res_width, res_height;
    logic [COORD_W-1:0] edge_left, edge_right;
    logic               res_changed, res_fault;

    always_comb
    begin
        // A missing left edge reads as the larger of search left and screen
        // width; a missing right edge reads as zero.
        if (left_found_next)
            edge_left = least_column_next;
        else
            edge_left = (s_left > screen_width_reg) ? s_left : screen_width_reg;
        edge_right = right_found_next ? greatest_column_next : COORD_ZERO;

        if (row_found_next)
        begin
            res_left    = edge_left;
            res_top     = first_row_next;
            res_width   = edge_right + COORD_ONE - edge_left;
            res_height  = final_row_next + COORD_ONE - first_row_next;
            res_changed = 1'b1;
            res_fault   = !(left_found_next && right_found_next);
        end
        else
        begin
            // No change: a unit box at the window corner, in either mode.
            res_left    = window_left_reg;
            res_top     = window_top_reg;
            res_width   = COORD_ONE;
            res_height  = COORD_ONE;
            res_changed = 1'b0;
            res_fault   = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic                     out_valid_reg;
    logic [4*COORD_W-1:0]     out_data_reg;
    logic [FLAG_W-1:0]        out_flags_reg;
    logic                     load_result;

    assign load_result = advance && in_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            out_data_reg                     <= {res_height, res_width, res_top, res_left};
            out_flags_reg[FLAG_CHANGED]      <= res_changed;
            out_flags_reg[FLAG_COLUMN_FAULT] <= res_fault;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flags_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A result without change is always the unit box without a fault.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[FLAG_CHANGED]) |->
            (m_tdata[3*COORD_W-1:2*COORD_W] == COORD_ONE)
            && (m_tdata[4*COORD_W-1:3*COORD_W] == COORD_ONE)
            && !m_tuser[FLAG_COLUMN_FAULT])
    else $error("no-change result is not a clean unit box");

    // Closing a frame leaves the tracking state empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_result |=> !row_found_reg && !left_found_reg && !right_found_reg)
    else $error("tracking state not cleared after the last pair");

    // A column edge is only ever found together with a row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (left_found_reg || right_found_reg) |-> row_found_reg)
    else $error("column edge tracked without a changed row");

    // A pair held in the input register is not dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg && $stable(in_last_reg))
    else $error("stalled pair lost from the input register");

endmodule

`default_nettype wire
